/* design/sbd_pkg.sv */
// ----------------------------------------------------------------------------
// sbd_pkg
// shared constants and types of the sliding brief descriptor
// ----------------------------------------------------------------------------
`default_nettype none
package sbd_pkg;

  localparam int unsigned DEF_MAX_PAIRS  = 32;
  localparam int unsigned DEF_MAX_WINDOW = 64;
  localparam int unsigned DEF_MAX_WIDTH  = 1024;
  localparam int unsigned DEF_MAX_HEIGHT = 1024;

  localparam int unsigned TABLE_DEPTH = 32;
  localparam int unsigned CODE_W      = 32;
  localparam int unsigned COORD_W     = 6;
  localparam int unsigned POS_W       = 10;
  localparam int unsigned PADDR_W     = 5;

  localparam logic [2:0] REG_THRESHOLD = 3'd0;
  localparam logic [2:0] REG_PAIRS     = 3'd1;
  localparam logic [2:0] REG_WINDOW    = 3'd2;
  localparam logic [2:0] REG_WIDTH     = 3'd3;
  localparam logic [2:0] REG_HEIGHT    = 3'd4;

  localparam logic CMD_PIXEL = 1'b0;
  localparam logic CMD_LOAD  = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ISSUE,
    ST_READ,
    ST_CMP,
    ST_OUT
  } sbd_state_t;

  // saturated configuration as used by the datapath
  typedef struct packed {
    logic [7:0]  threshold;
    logic [6:0]  pairs;
    logic [7:0]  window;
    logic [12:0] width;
    logic [12:0] height;
  } sbd_cfg_t;

endpackage
`default_nettype wire

/* design/sbd_regs.sv */
// ----------------------------------------------------------------------------
// sbd_regs
// configuration register file with saturation of the used values
// ----------------------------------------------------------------------------
`default_nettype none
module sbd_regs
  import sbd_pkg::*;
#(
  parameter int unsigned MAX_PAIRS  = DEF_MAX_PAIRS,
  parameter int unsigned MAX_WINDOW = DEF_MAX_WINDOW,
  parameter int unsigned MAX_WIDTH  = DEF_MAX_WIDTH,
  parameter int unsigned MAX_HEIGHT = DEF_MAX_HEIGHT
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               psel,
  input  wire logic               penable,
  input  wire logic               pwrite,
  input  wire logic [PADDR_W-1:0] paddr,
  input  wire logic [31:0]        pwdata,
  output logic      [31:0]        prdata,
  output sbd_cfg_t                cfg
);

  localparam int unsigned PC_MAX = (MAX_PAIRS < 32) ? MAX_PAIRS : 32;

  logic [7:0]  thr_r;
  logic [5:0]  pc_r;
  logic [6:0]  ws_r;
  logic [10:0] w_r;
  logic [10:0] h_r;
  logic        wr;

  assign wr = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r <= 8'd0;
      pc_r  <= 6'd9;
      ws_r  <= 7'd7;
      w_r   <= 11'd640;
      h_r   <= 11'd480;
    end else if (wr) begin
      unique case (paddr[4:2])
        REG_THRESHOLD: thr_r <= pwdata[7:0];
        REG_PAIRS:     pc_r  <= pwdata[5:0];
        REG_WINDOW:    ws_r  <= pwdata[6:0];
        REG_WIDTH:     w_r   <= pwdata[10:0];
        REG_HEIGHT:    h_r   <= pwdata[10:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[4:2])
      REG_THRESHOLD: prdata = {24'd0, thr_r};
      REG_PAIRS:     prdata = {26'd0, pc_r};
      REG_WINDOW:    prdata = {25'd0, ws_r};
      REG_WIDTH:     prdata = {21'd0, w_r};
      REG_HEIGHT:    prdata = {21'd0, h_r};
      default:       prdata = 32'd0;
    endcase
  end

  always_comb begin
    cfg.threshold = thr_r;
    if (pc_r == 6'd0)                   cfg.pairs = 7'd1;
    else if (32'(pc_r) > PC_MAX)        cfg.pairs = 7'(PC_MAX);
    else                                cfg.pairs = {1'b0, pc_r};
    if (ws_r < 7'd2)                    cfg.window = 8'd2;
    else if (32'(ws_r) > MAX_WINDOW)    cfg.window = 8'(MAX_WINDOW);
    else                                cfg.window = {1'b0, ws_r};
    if (w_r < 11'd2)                    cfg.width = 13'd2;
    else if (32'(w_r) > MAX_WIDTH)      cfg.width = 13'(MAX_WIDTH);
    else                                cfg.width = {2'b0, w_r};
    if (h_r < 11'd2)                    cfg.height = 13'd2;
    else if (32'(h_r) > MAX_HEIGHT)     cfg.height = 13'(MAX_HEIGHT);
    else                                cfg.height = {2'b0, h_r};
  end

endmodule
`default_nettype wire

/* design/sbd_store.sv */
// ----------------------------------------------------------------------------
// sbd_store
// line store memory: one write port, two registered read ports
// ----------------------------------------------------------------------------
`default_nettype none
module sbd_store #(
  parameter int unsigned DEPTH = 65536,
  parameter int unsigned AW    = $clog2(DEPTH)
) (
  input  wire logic          clk,
  input  wire logic          we,
  input  wire logic [AW-1:0] waddr,
  input  wire logic [7:0]    wdata,
  input  wire logic [AW-1:0] raddr_a,
  input  wire logic [AW-1:0] raddr_b,
  output logic      [7:0]    rdata_a,
  output logic      [7:0]    rdata_b
);

  logic [7:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata_a <= mem[raddr_a];
    rdata_b <= mem[raddr_b];
  end

endmodule
`default_nettype wire

/* design/sliding_brief_descriptor.sv */
// ----------------------------------------------------------------------------
// sliding_brief_descriptor
// binary descriptor over every overlapping window of a raster pixel stream
// ----------------------------------------------------------------------------
//  channel | ports                        | role
//  in_     | valid/ready, command..col    | pixel or pair-table load item
//  out_    | valid/ready, code..frame_end | one code per full window
//  cfg_    | apb psel..pready             | threshold, pairs, geometry
//
//  a load item and a pixel with no window leave the block idle;
//  a pixel that completes a window steps through ISSUE, READ, CMP per pair, then OUT: the
//  shared address/compare unit walks the pairs, one line store read pair each
//  the finished item waits in the output register; the next item is taken
//  while it waits unless a new code is ready to be written over it
//  reset (synchronous, rst_n low) clears position, control and registers;
//  pair table and line store hold no reset
// ----------------------------------------------------------------------------
`default_nettype none
module sliding_brief_descriptor
  import sbd_pkg::*;
#(
  parameter int unsigned MAX_PAIRS  = DEF_MAX_PAIRS,
  parameter int unsigned MAX_WINDOW = DEF_MAX_WINDOW,
  parameter int unsigned MAX_WIDTH  = DEF_MAX_WIDTH,
  parameter int unsigned MAX_HEIGHT = DEF_MAX_HEIGHT
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic               in_command,
  input  wire logic [7:0]         in_pixel,
  input  wire logic               in_start_frame,
  input  wire logic [4:0]         in_pair_slot,
  input  wire logic [5:0]         in_first_row,
  input  wire logic [5:0]         in_first_col,
  input  wire logic [5:0]         in_second_row,
  input  wire logic [5:0]         in_second_col,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic      [31:0]        out_code,
  output logic      [9:0]         out_win_row,
  output logic      [9:0]         out_win_col,
  output logic                    out_frame_end,
  input  wire logic               cfg_psel,
  input  wire logic               cfg_penable,
  input  wire logic               cfg_pwrite,
  input  wire logic [PADDR_W-1:0] cfg_paddr,
  input  wire logic [31:0]        cfg_pwdata,
  output logic      [31:0]        cfg_prdata,
  output logic                    cfg_pready
);

  localparam int unsigned RW     = $clog2(MAX_WINDOW);
  localparam int unsigned CW     = $clog2(MAX_WIDTH);
  localparam int unsigned SAW    = RW + CW;
  localparam int unsigned DEPTH  = MAX_WINDOW * MAX_WIDTH;
  localparam int unsigned PW     = $clog2(TABLE_DEPTH);
  localparam int unsigned TS     = (MAX_PAIRS < TABLE_DEPTH) ? MAX_PAIRS : TABLE_DEPTH;

  sbd_cfg_t cfg;
  assign cfg_pready = 1'b1;

  sbd_regs #(
    .MAX_PAIRS(MAX_PAIRS), .MAX_WINDOW(MAX_WINDOW),
    .MAX_WIDTH(MAX_WIDTH), .MAX_HEIGHT(MAX_HEIGHT)
  ) u_regs (
    .clk, .rst_n,
    .psel(cfg_psel), .penable(cfg_penable), .pwrite(cfg_pwrite),
    .paddr(cfg_paddr), .pwdata(cfg_pwdata), .prdata(cfg_prdata), .cfg
  );

  // pair table: small, read at one sequencer address
  logic [23:0] pair_mem [TABLE_DEPTH];
  logic [23:0] pair_q_r;

  sbd_state_t state_r, state_nxt;
  logic [12:0] row_r, col_r;        // current position
  logic [12:0] prow_r, pcol_r;      // position of pixel in work
  logic [6:0]  idx_r;
  logic [31:0] code_r;
  logic        last_r;
  logic [7:0]  ws1;

  logic        acc;
  assign in_ready = (state_r == ST_IDLE);
  assign acc      = in_valid && in_ready;
  assign ws1      = cfg.window - 8'd1;

  // position adjust before the pixel is taken
  logic [12:0] r0, c0, r1, c1;
  always_comb begin
    r0 = in_start_frame ? 13'd0 : row_r;
    c0 = in_start_frame ? 13'd0 : col_r;
    if (c0 >= cfg.width) begin
      c1 = 13'd0;
      r1 = r0 + 13'd1;
    end else begin
      c1 = c0;
      r1 = r0;
    end
    if (r1 >= cfg.height) r1 = 13'd0;
  end

  // line store write
  logic            st_we;
  logic [SAW-1:0]  st_waddr;
  assign st_we    = acc && (in_command == CMD_PIXEL);
  assign st_waddr = {r1[RW-1:0], c1[CW-1:0]};

  // shared sample address unit: clamp then add to window origin
  logic [12:0] top, left;
  assign top  = prow_r - 13'(ws1);
  assign left = pcol_r - 13'(ws1);

  function automatic logic [5:0] clampc(input logic [5:0] v, input logic [7:0] m);
    return ({2'b0, v} > m) ? m[5:0] : v;
  endfunction

  logic [12:0] ar, ac, br, bc;
  always_comb begin
    ar = top  + 13'(clampc(pair_q_r[23:18], ws1));
    ac = left + 13'(clampc(pair_q_r[17:12], ws1));
    br = top  + 13'(clampc(pair_q_r[11:6], ws1));
    bc = left + 13'(clampc(pair_q_r[5:0], ws1));
  end

  logic [7:0] da, db;
  sbd_store #(.DEPTH(DEPTH), .AW(SAW)) u_store (
    .clk, .we(st_we), .waddr(st_waddr), .wdata(in_pixel),
    .raddr_a({ar[RW-1:0], ac[CW-1:0]}), .raddr_b({br[RW-1:0], bc[CW-1:0]}),
    .rdata_a(da), .rdata_b(db)
  );

  // compare unit: a - b > threshold, i.e. a > b + threshold
  logic hit;
  assign hit = {1'b0, da} > ({1'b0, db} + {1'b0, cfg.threshold});

  logic win_ok;
  assign win_ok = (r1 >= 13'(ws1)) && (c1 >= 13'(ws1));

  always_ff @(posedge clk) begin
    if (acc && in_command == CMD_LOAD && 32'(in_pair_slot) < TS)
      pair_mem[in_pair_slot] <= {in_first_row, in_first_col, in_second_row, in_second_col};
    pair_q_r <= pair_mem[idx_r[PW-1:0]];
  end

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= ST_IDLE;
    else        state_r <= state_nxt;
  end

  // sequencer: issue reads pair table, read reads store, cmp folds a bit, out loads the output register
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE:  if (acc && in_command == CMD_PIXEL && win_ok) state_nxt = ST_ISSUE;
      ST_ISSUE: state_nxt = ST_READ;
      ST_READ:  state_nxt = ST_CMP;
      ST_CMP:   state_nxt = (idx_r + 7'd1 >= cfg.pairs) ? ST_OUT : ST_ISSUE;
      ST_OUT:   if (!out_valid || out_ready) state_nxt = ST_IDLE;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_r     <= 13'd0;
      col_r     <= 13'd0;
      out_valid <= 1'b0;
      idx_r     <= 7'd0;
    end else begin
      if (acc && in_command == CMD_PIXEL) begin
        prow_r <= r1;
        pcol_r <= c1;
        last_r <= (r1 == cfg.height - 13'd1) && (c1 == cfg.width - 13'd1);
        code_r <= 32'd0;
        idx_r  <= 7'd0;
        if (c1 + 13'd1 >= cfg.width) begin
          col_r <= 13'd0;
          row_r <= (r1 + 13'd1 >= cfg.height) ? 13'd0 : r1 + 13'd1;
        end else begin
          col_r <= c1 + 13'd1;
          row_r <= r1;
        end
      end
      if (state_r == ST_CMP) begin
        code_r <= {code_r[30:0], hit};
        idx_r  <= idx_r + 7'd1;
      end
      if (state_r == ST_OUT && (!out_valid || out_ready)) begin
        out_valid     <= 1'b1;
        out_code      <= code_r;
        out_win_row   <= top[9:0];
        out_win_col   <= left[9:0];
        out_frame_end <= last_r;
      end else if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule
`default_nettype wire

/* design/sbd_checker.sv */
// ----------------------------------------------------------------------------
// sbd_checker
// port-level assertions for the sliding brief descriptor
// ----------------------------------------------------------------------------
`default_nettype none
module sbd_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_ready,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic [31:0] out_code,
  input wire logic        cfg_pready
);

  ap_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_code))
    else $error("result dropped or changed while stalled");

  ap_pready: assert property (@(posedge clk) cfg_pready)
    else $error("pready low");

  ap_busy: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> !$past(in_ready))
    else $error("result appeared without work in progress");

  ap_reset: assert property (@(posedge clk) !rst_n |=> !out_valid && in_ready)
    else $error("reset state wrong");

endmodule

bind sliding_brief_descriptor sbd_checker u_chk (
  .clk, .rst_n, .in_ready, .out_valid, .out_ready,
  .out_code, .cfg_pready
);
`default_nettype wire

/* tb/sv/sbd_checker.sv */
// ----------------------------------------------------------------------------
// sbd_scoreboard
// watches the pixel, code and register ports, predicts every window code
// and compares each accepted code field by field with the oldest prediction
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps
module sbd_scoreboard
  import sbd_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic               in_ready,
  input  logic               in_command,
  input  logic [7:0]         in_pixel,
  input  logic               in_start_frame,
  input  logic [4:0]         in_pair_slot,
  input  logic [5:0]         in_first_row,
  input  logic [5:0]         in_first_col,
  input  logic [5:0]         in_second_row,
  input  logic [5:0]         in_second_col,
  input  logic               out_valid,
  input  logic               out_ready,
  input  logic [31:0]        out_code,
  input  logic [9:0]         out_win_row,
  input  logic [9:0]         out_win_col,
  input  logic               out_frame_end,
  input  logic               cfg_psel,
  input  logic               cfg_penable,
  input  logic               cfg_pwrite,
  input  logic [PADDR_W-1:0] cfg_paddr,
  input  logic [31:0]        cfg_pwdata,
  input  logic               cfg_pready,
  output int                 errors,
  output int                 pending
);

  typedef struct {
    logic [31:0] code;
    logic [9:0]  row;
    logic [9:0]  col;
    logic        last;
  } window_code_t;

  localparam int unsigned ROWS = DEF_MAX_WINDOW;
  localparam int unsigned COLS = DEF_MAX_WIDTH;

  logic [7:0]  thr_q;
  logic [5:0]  pairs_q;
  logic [6:0]  win_q;
  logic [10:0] width_q;
  logic [10:0] height_q;

  logic [5:0] pa_row [TABLE_DEPTH];
  logic [5:0] pa_col [TABLE_DEPTH];
  logic [5:0] pb_row [TABLE_DEPTH];
  logic [5:0] pb_col [TABLE_DEPTH];
  logic [7:0] rows_mem [ROWS*COLS];
  int unsigned row_pos;
  int unsigned col_pos;
  window_code_t codes_due[$];
  int err_cnt;

  function automatic int unsigned sat(int unsigned v, int unsigned lo, int unsigned hi);
    return (v < lo) ? lo : ((v > hi) ? hi : v);
  endfunction

  function automatic int sample(int unsigned top, int unsigned left, int unsigned r,
                                int unsigned c, int unsigned ws);
    if (r > ws - 1) r = ws - 1;
    if (c > ws - 1) c = ws - 1;
    return 32'(rows_mem[((top + r) % ROWS) * COLS + ((left + c) % COLS)]);
  endfunction

  function automatic void take_pixel(logic [7:0] pix, logic sof);
    int unsigned pc, ws, w, h, r, c, top, left;
    int a, b;
    window_code_t wc;
    pc = sat(32'(pairs_q), 1, (DEF_MAX_PAIRS < 32) ? DEF_MAX_PAIRS : 32);
    ws = sat(32'(win_q), 2, DEF_MAX_WINDOW);
    w  = sat(32'(width_q), 2, DEF_MAX_WIDTH);
    h  = sat(32'(height_q), 2, DEF_MAX_HEIGHT);
    if (sof) begin
      row_pos = 0;
      col_pos = 0;
    end
    // geometry may have shrunk under the current position
    if (col_pos >= w) begin
      col_pos = 0;
      row_pos++;
    end
    if (row_pos >= h) row_pos = 0;
    r = row_pos;
    c = col_pos;
    rows_mem[(r % ROWS) * COLS + (c % COLS)] = pix;
    if (r >= ws - 1 && c >= ws - 1) begin
      top = r - (ws - 1);
      left = c - (ws - 1);
      wc.code = '0;
      for (int i = 0; i < pc; i++) begin
        a = sample(top, left, 32'(pa_row[i]), 32'(pa_col[i]), ws);
        b = sample(top, left, 32'(pb_row[i]), 32'(pb_col[i]), ws);
        if (a - b > int'(thr_q)) wc.code[pc-1-i] = 1'b1;
      end
      wc.row  = top[9:0];
      wc.col  = left[9:0];
      wc.last = (r == h - 1) && (c == w - 1);
      codes_due.insert(codes_due.size(), wc);
    end
    if (c + 1 >= w) begin
      col_pos = 0;
      row_pos = (r + 1 >= h) ? 0 : r + 1;
    end else begin
      col_pos = c + 1;
    end
  endfunction

  always @(posedge clk) begin
    window_code_t want;
    if (!rst_n) begin
      thr_q    = 8'd0;
      pairs_q  = 6'd9;
      win_q    = 7'd7;
      width_q  = 11'd640;
      height_q = 11'd480;
      row_pos  = 0;
      col_pos  = 0;
      codes_due.delete();
      err_cnt  = 0;
    end else begin
      if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready) begin
        case (cfg_paddr[4:2])
          REG_THRESHOLD: thr_q    = cfg_pwdata[7:0];
          REG_PAIRS:     pairs_q  = cfg_pwdata[5:0];
          REG_WINDOW:    win_q    = cfg_pwdata[6:0];
          REG_WIDTH:     width_q  = cfg_pwdata[10:0];
          REG_HEIGHT:    height_q = cfg_pwdata[10:0];
          default: ;
        endcase
      end
      if (out_valid && out_ready) begin
        if (codes_due.size() == 0) begin
          err_cnt++;
          $display("%0t unexpected code: expected none, got %h row %0d col %0d",
                   $time, out_code, out_win_row, out_win_col);
        end else begin
          want = codes_due.pop_front();
          if (out_code !== want.code) begin
            err_cnt++;
            $display("%0t code: expected %h, got %h", $time, want.code, out_code);
          end
          if (out_win_row !== want.row) begin
            err_cnt++;
            $display("%0t win_row: expected %0d, got %0d", $time, want.row, out_win_row);
          end
          if (out_win_col !== want.col) begin
            err_cnt++;
            $display("%0t win_col: expected %0d, got %0d", $time, want.col, out_win_col);
          end
          if (out_frame_end !== want.last) begin
            err_cnt++;
            $display("%0t frame_end: expected %b, got %b", $time, want.last,
                     out_frame_end);
          end
        end
      end
      if (in_valid && in_ready) begin
        if (in_command == CMD_LOAD) begin
          pa_row[in_pair_slot] = in_first_row;
          pa_col[in_pair_slot] = in_first_col;
          pb_row[in_pair_slot] = in_second_row;
          pb_col[in_pair_slot] = in_second_col;
        end else begin
          take_pixel(in_pixel, in_start_frame);
        end
      end
    end
    errors  <= err_cnt;
    pending <= codes_due.size();
  end

endmodule

/* tb/sv/sliding_brief_descriptor_tb.sv */
// ----------------------------------------------------------------------------
// sliding_brief_descriptor_tb
// fills the pair table, streams small frames under many register settings
// with random gaps and stalls, and reports the checker's verdict
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps
module sliding_brief_descriptor_tb;
  import sbd_pkg::*;

  localparam int TARGET_ITEMS = 1350;
  localparam int IDLE_LIMIT   = 6000;   // cycles with no item moving
  localparam int LONG_HOLD    = 900;    // one long receiver stall
  localparam int DRAIN_WAIT   = 110;    // about one full 32-pair window

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic in_command = CMD_PIXEL;
  logic [7:0] in_pixel = '0;
  logic in_start_frame = 1'b0;
  logic [4:0] in_pair_slot = '0;
  logic [5:0] in_first_row = '0, in_first_col = '0, in_second_row = '0, in_second_col = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [31:0] out_code;
  logic [9:0] out_win_row, out_win_col;
  logic out_frame_end;
  logic cfg_psel = 1'b0, cfg_penable = 1'b0, cfg_pwrite = 1'b0;
  logic [PADDR_W-1:0] cfg_paddr = '0;
  logic [31:0] cfg_pwdata = '0;
  logic [31:0] cfg_prdata;
  logic cfg_pready;
  int errors, pending;

  int items_sent = 0;
  int codes_seen = 0;
  bit no_gaps = 1'b0;     // stretches where both sides run flat out
  int last_width = 0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  sliding_brief_descriptor dut (.*);

  sbd_scoreboard u_checker (.*);

  // mostly short gaps, a few long ones
  function automatic int pick_gap();
    int roll;
    roll = $urandom_range(0, 99);
    if (no_gaps || roll < 60) return 0;
    if (roll < 93) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // receiver: random stalls after each code, one long hold-off while the
  // sender keeps offering items so the block backs up into its input
  initial begin
    int hold;
    bit held_long;
    hold = 0;
    held_long = 1'b0;
    @(posedge clk iff rst_n);
    forever begin
      @(posedge clk);
      if (out_valid && out_ready) begin
        codes_seen++;
        if (!held_long && codes_seen == 40) begin
          held_long = 1'b1;
          hold = LONG_HOLD;
        end else begin
          hold = pick_gap();
        end
      end
      if (hold > 0) begin
        hold--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // watchdog on cycles where neither channel moves an item
  initial begin
    int quiet;
    quiet = 0;
    forever begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready)) quiet = 0;
      else quiet++;
      if (quiet >= IDLE_LIMIT) begin
        $display("DONE: errors detected");
        $finish;
      end
    end
  end

  task automatic write_reg(logic [2:0] idx, logic [31:0] val);
    cfg_psel <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b1;
    cfg_paddr <= {idx, 2'b00};
    cfg_pwdata <= val;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
    @(posedge clk);
  endtask

  // one item on the input channel; valid stays up across back-to-back items
  task automatic push_item(logic cmd, logic [7:0] pix, logic sof, logic [4:0] slot,
                           logic [5:0] fr, logic [5:0] fc, logic [5:0] sr, logic [5:0] sc);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_command <= cmd;
    in_pixel <= pix;
    in_start_frame <= sof;
    in_pair_slot <= slot;
    in_first_row <= fr;
    in_first_col <= fc;
    in_second_row <= sr;
    in_second_col <= sc;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    items_sent++;
  endtask

  // fields that a load ignores are randomized so every bit toggles
  task automatic load_pair(logic [4:0] slot, logic [5:0] fr, logic [5:0] fc,
                           logic [5:0] sr, logic [5:0] sc);
    push_item(CMD_LOAD, 8'($urandom()), 1'($urandom_range(0, 1)), slot, fr, fc, sr, sc);
  endtask

  task automatic send_pixel(logic [7:0] pix, logic sof);
    push_item(CMD_PIXEL, pix, sof, 5'($urandom()), 6'($urandom()), 6'($urandom()),
              6'($urandom()), 6'($urandom()));
  endtask

  // block idle: every code in and the last no-code item worked off
  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
  endtask

  // one register setting followed by a run of pixels; fresh marks the
  // first pixel as a frame start, otherwise the stream carries on from the
  // old position under the new geometry
  task automatic run_phase(int thr, int pc, int ws, int w, int h, int npix, bit fresh);
    settle();
    write_reg(REG_THRESHOLD, 32'(thr));
    write_reg(REG_PAIRS, 32'(pc));
    write_reg(REG_WINDOW, 32'(ws));
    write_reg(REG_WIDTH, 32'(w));
    write_reg(REG_HEIGHT, 32'(h));
    for (int i = 0; i < npix; i++) begin
      if ($urandom_range(0, 99) < 6)
        load_pair(5'($urandom()), 6'($urandom()), 6'($urandom()), 6'($urandom()),
                  6'($urandom()));
      if ((i % 60) == 0) no_gaps = ($urandom_range(0, 3) == 0);
      send_pixel(8'($urandom()), (i == 0) ? fresh : ($urandom_range(0, 79) == 0));
    end
    no_gaps = 1'b0;
    last_width = (w < 2) ? 2 : ((w > 1024) ? 1024 : w);
  endtask

  initial begin
    int ws, w, h, thr;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // pair table filled before any window can read it, corner points first
    load_pair(5'd0, 6'd0, 6'd0, 6'd63, 6'd63);
    load_pair(5'd1, 6'd63, 6'd63, 6'd0, 6'd0);
    for (int s = 2; s < TABLE_DEPTH; s++)
      load_pair(5'(s), 6'($urandom()), 6'($urandom()), 6'($urandom()), 6'($urandom()));
    // reset geometry is far larger than these few pixels: no codes
    for (int i = 0; i < 6; i++) send_pixel(8'($urandom()), i == 0);

    // directed settings: field extremes, saturation, degenerate geometry
    run_phase(0, 32, 3, 8, 5, 40, 1'b1);
    run_phase(255, 1, 2, 5, 4, 20, 1'b1);
    run_phase(7, 32, 5, 5, 5, 25, 1'b1);          // window equals the frame
    run_phase(0, 63, 127, 6, 4, 24, 1'b1);        // window larger than frame
    run_phase(5, 0, 0, 0, 2047, 20, 1'b1);        // all registers but the threshold saturated
    // stop mid-frame, then shrink so the position wraps by itself
    run_phase(10, 16, 4, 10, 8, 57, 1'b1);
    run_phase(3, 20, 3, 6, 4, 30, 1'b0);

    while (items_sent < TARGET_ITEMS) begin
      ws = ($urandom_range(0, 7) == 0) ? $urandom_range(2, 12) : $urandom_range(2, 6);
      w = $urandom_range((ws > 3) ? ws - 1 : 2, 14);
      h = $urandom_range((ws > 3) ? ws - 1 : 2, 10);
      thr = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 255) : $urandom_range(0, 30);
      // continuing without a frame start is safe only if rows above were
      // written at least as wide as the new width
      run_phase(thr, $urandom_range(1, 32), ws, w, h,
                $urandom_range(w * h / 2, 2 * w * h),
                (w <= last_width) ? 1'($urandom_range(0, 1)) : 1'b1);
    end

    settle();
    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

/* files.f */
design/sbd_pkg.sv
design/sbd_regs.sv
design/sbd_store.sv
design/sliding_brief_descriptor.sv
design/sbd_checker.sv
tb/sv/sbd_checker.sv
tb/sv/sliding_brief_descriptor_tb.sv
